FILE: sv/cmhc_pkg.sv
// Package: shared types and register codes for the charger mode hysteresis controller.
`timescale 1ns / 1ps

package cmhc_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 32;
    localparam int unsigned TimeWidth     = 32;
    localparam int unsigned LevelWidth    = 7;

    localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE_INTERVAL = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_AUTO_ENABLE       = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_OVERRIDE_MODE     = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_RECHARGE_LEVEL    = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_QUIET_LEVEL       = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_DWELL_INTERVAL    = 3'd5;

    localparam logic [TimeWidth-1:0]  DEBOUNCE_RESET = 32'd5000;
    localparam logic                  AUTO_RESET     = 1'b1;
    localparam logic                  OVERRIDE_RESET = 1'b0;
    localparam logic [LevelWidth-1:0] RECHARGE_RESET = 7'd50;
    localparam logic [LevelWidth-1:0] QUIET_RESET    = 7'd90;
    localparam logic [TimeWidth-1:0]  DWELL_RESET    = 32'd300000;

    localparam logic MODE_CHARGE = 1'b0;
    localparam logic MODE_QUIET  = 1'b1;

    typedef struct packed {
        logic [TimeWidth-1:0]  debounce_interval;
        logic                  auto_enable;
        logic                  override_mode;
        logic [LevelWidth-1:0] recharge_level;
        logic [LevelWidth-1:0] quiet_level;
        logic [TimeWidth-1:0]  dwell_interval;
    } cfg_t;

    typedef struct packed {
        logic [TimeWidth-1:0]  time_now;
        logic                  reading_valid;
        logic                  grid_seen;
        logic                  fault_seen;
        logic [LevelWidth-1:0] charge_level;
    } item_t;

endpackage

FILE: sv/charger_mode_hysteresis_controller.sv
// Top level: input register, controller core and result register of the charger mode controller.
//
//  channel   direction  handshake           payload
//  s_*       in         s_valid / s_ready   time_now, reading_valid, grid_seen, fault_seen,
//                                           charge_level
//  m_*       out        m_valid / m_ready   charger_mode
//  cfg_*     in         cfg_we (no wait)    cfg_index, cfg_wdata
//
// One beat per cycle while m_ready takes each result; a beat passes the input register, then the result register.
// The mode and debounce state update in the same cycle the result is registered,
// so the next beat sees it with no bubble.
// Synchronous active-low reset clears state, valids and config registers to defaults; the data registers are not reset.
// A stalled result holds its register; the input register fills behind it, then
// s_ready drops until m_ready frees the result slot.
`timescale 1ns / 1ps

module charger_mode_hysteresis_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [cmhc_pkg::TimeWidth-1:0]      s_time_now,
    input  logic                                s_reading_valid,
    input  logic                                s_grid_seen,
    input  logic                                s_fault_seen,
    input  logic [cmhc_pkg::LevelWidth-1:0]     s_charge_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_charger_mode,
    input  logic                                cfg_we,
    input  logic [cmhc_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [cmhc_pkg::CfgDataWidth-1:0]   cfg_wdata
);

    cmhc_pkg::cfg_t  cfg;
    cmhc_pkg::item_t item_reg;
    logic            in_valid_reg;
    logic            m_valid_reg;
    logic            m_charger_mode_reg;
    logic            mode_next;
    logic            advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    cmhc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cmhc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (item_reg),
        .cfg       (cfg),
        .mode_next (mode_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.time_now      <= s_time_now;
            item_reg.reading_valid <= s_reading_valid;
            item_reg.grid_seen     <= s_grid_seen;
            item_reg.fault_seen    <= s_fault_seen;
            item_reg.charge_level  <= s_charge_level;
        end
        if (advance) begin
            m_charger_mode_reg <= mode_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_charger_mode = m_charger_mode_reg;

endmodule

FILE: sv/cmhc_cfg_regs.sv
// Configuration register file for the charger mode hysteresis controller.
`timescale 1ns / 1ps

module cmhc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [cmhc_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [cmhc_pkg::CfgDataWidth-1:0]   cfg_wdata,
    output cmhc_pkg::cfg_t                      cfg
);

    cmhc_pkg::cfg_t cfg_reg;
    cmhc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                cmhc_pkg::REG_DEBOUNCE_INTERVAL: cfg_next.debounce_interval = cfg_wdata;
                cmhc_pkg::REG_AUTO_ENABLE:       cfg_next.auto_enable       = cfg_wdata[0];
                cmhc_pkg::REG_OVERRIDE_MODE:     cfg_next.override_mode     = cfg_wdata[0];
                cmhc_pkg::REG_RECHARGE_LEVEL:
                    cfg_next.recharge_level = cfg_wdata[cmhc_pkg::LevelWidth-1:0];
                cmhc_pkg::REG_QUIET_LEVEL:
                    cfg_next.quiet_level = cfg_wdata[cmhc_pkg::LevelWidth-1:0];
                cmhc_pkg::REG_DWELL_INTERVAL:    cfg_next.dwell_interval    = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_interval <= cmhc_pkg::DEBOUNCE_RESET;
            cfg_reg.auto_enable       <= cmhc_pkg::AUTO_RESET;
            cfg_reg.override_mode     <= cmhc_pkg::OVERRIDE_RESET;
            cfg_reg.recharge_level    <= cmhc_pkg::RECHARGE_RESET;
            cfg_reg.quiet_level       <= cmhc_pkg::QUIET_RESET;
            cfg_reg.dwell_interval    <= cmhc_pkg::DWELL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/cmhc_core.sv
// Debouncer, mode hysteresis and dwell logic with the controller state registers.
`timescale 1ns / 1ps

module cmhc_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  cmhc_pkg::item_t item,
    input  cmhc_pkg::cfg_t  cfg,
    output logic            mode_next
);

    logic                               started_reg;
    logic                               has_switched_reg, has_switched_next;
    logic                               raw_grid_reg, raw_grid_next;
    logic                               filtered_grid_reg, filtered_grid_next;
    logic [cmhc_pkg::TimeWidth-1:0]     grid_change_time_reg, grid_change_time_next;
    logic [cmhc_pkg::TimeWidth-1:0]     switch_time_reg, switch_time_next;
    logic                               mode_reg;

    // state as seen by this beat (first beat seeds from the reading)
    logic                               eff_has_switched;
    logic                               eff_raw;
    logic                               eff_filtered;
    logic [cmhc_pkg::TimeWidth-1:0]     eff_gct;
    logic [cmhc_pkg::TimeWidth-1:0]     eff_switch_time;
    logic                               eff_mode;
    logic [cmhc_pkg::TimeWidth-1:0]     grid_age;
    logic [cmhc_pkg::TimeWidth-1:0]     dwell_age;
    logic                               target;

    always_comb begin
        if (started_reg) begin
            eff_has_switched = has_switched_reg;
            eff_raw          = raw_grid_reg;
            eff_filtered     = filtered_grid_reg;
            eff_gct          = grid_change_time_reg;
            eff_switch_time  = switch_time_reg;
            eff_mode         = mode_reg;
        end else begin
            eff_has_switched = 1'b0;
            eff_raw          = item.grid_seen;
            eff_filtered     = item.grid_seen;
            eff_gct          = item.time_now;
            eff_switch_time  = item.time_now;
            eff_mode         = cmhc_pkg::MODE_CHARGE;
        end

        raw_grid_next         = eff_raw;
        grid_change_time_next = eff_gct;
        if (item.reading_valid && (item.grid_seen != eff_raw)) begin
            raw_grid_next         = item.grid_seen;
            grid_change_time_next = item.time_now;
        end
        grid_age = item.time_now - grid_change_time_next;
        filtered_grid_next = eff_filtered;
        if (item.reading_valid && (grid_age >= cfg.debounce_interval)) begin
            filtered_grid_next = raw_grid_next;
        end

        dwell_age = item.time_now - eff_switch_time;
        target    = eff_mode;
        if (!cfg.auto_enable) begin
            target = cfg.override_mode;
        end else if (!item.reading_valid || item.fault_seen) begin
            target = cmhc_pkg::MODE_CHARGE;
        end else if (eff_mode == cmhc_pkg::MODE_QUIET) begin
            if (!filtered_grid_next || (item.charge_level <= cfg.recharge_level)) begin
                target = cmhc_pkg::MODE_CHARGE;
            end
        end else begin
            if (filtered_grid_next && (item.charge_level >= cfg.quiet_level) &&
                (!eff_has_switched || (dwell_age >= cfg.dwell_interval))) begin
                target = cmhc_pkg::MODE_QUIET;
            end
        end

        mode_next         = target;
        has_switched_next = eff_has_switched;
        switch_time_next  = eff_switch_time;
        if (target != eff_mode) begin
            has_switched_next = 1'b1;
            switch_time_next  = item.time_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg          <= 1'b0;
            has_switched_reg     <= 1'b0;
            raw_grid_reg         <= 1'b0;
            filtered_grid_reg    <= 1'b0;
            grid_change_time_reg <= '0;
            switch_time_reg      <= '0;
            mode_reg             <= cmhc_pkg::MODE_CHARGE;
        end else if (step) begin
            started_reg          <= 1'b1;
            has_switched_reg     <= has_switched_next;
            raw_grid_reg         <= raw_grid_next;
            filtered_grid_reg    <= filtered_grid_next;
            grid_change_time_reg <= grid_change_time_next;
            switch_time_reg      <= switch_time_next;
            mode_reg             <= mode_next;
        end
    end

endmodule

FILE: sim/charger_mode_hysteresis_controller_test.sv
// Testbench: charger mode controller driven with directed and random ticks, checked against a mode predictor.
`timescale 1ns / 1ps

module charger_mode_hysteresis_controller_test;
    import cmhc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned IDLE_PERCENT    = 37;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned TAIL_CYCLES     = 10;

    localparam logic [CfgIndexWidth-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CfgIndexWidth-1:0] REG_SPARE_B = 3'd7;

    class mode_tracker;
        logic [TimeWidth-1:0]  debounce_ms;
        logic                  auto_on;
        logic                  forced_mode;
        logic [LevelWidth-1:0] recharge_pct;
        logic [LevelWidth-1:0] quiet_pct;
        logic [TimeWidth-1:0]  dwell_ms;

        logic                  started;
        logic                  has_switched;
        logic                  raw_grid;
        logic                  filtered_grid;
        logic [TimeWidth-1:0]  grid_change_ms;
        logic [TimeWidth-1:0]  switch_ms;
        logic                  mode_now;

        logic expected_modes[$];
        int   mismatches;
        int   checked;
        int   quiet_seen;
        int   ticks;

        function new();
            debounce_ms    = DEBOUNCE_RESET;
            auto_on        = AUTO_RESET;
            forced_mode    = OVERRIDE_RESET;
            recharge_pct   = RECHARGE_RESET;
            quiet_pct      = QUIET_RESET;
            dwell_ms       = DWELL_RESET;
            started        = 1'b0;
            has_switched   = 1'b0;
            raw_grid       = 1'b0;
            filtered_grid  = 1'b0;
            grid_change_ms = '0;
            switch_ms      = '0;
            mode_now       = MODE_CHARGE;
            mismatches     = 0;
            checked        = 0;
            quiet_seen     = 0;
            ticks          = 0;
        endfunction

        function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
            case (idx)
                REG_DEBOUNCE_INTERVAL: debounce_ms = data;
                REG_AUTO_ENABLE:       auto_on = data[0];
                REG_OVERRIDE_MODE:     forced_mode = data[0];
                REG_RECHARGE_LEVEL:    recharge_pct = data[LevelWidth-1:0];
                REG_QUIET_LEVEL:       quiet_pct = data[LevelWidth-1:0];
                REG_DWELL_INTERVAL:    dwell_ms = data;
                default: ;
            endcase
        endfunction

        function void move_to(logic target, logic [TimeWidth-1:0] now);
            if (mode_now != target) begin
                mode_now     = target;
                switch_ms    = now;
                has_switched = 1'b1;
            end
        endfunction

        function void note_tick(item_t t);
            logic [TimeWidth-1:0] now;
            logic [TimeWidth-1:0] elapsed;
            logic                 target;
            now = t.time_now;
            ticks++;
            if (!started) begin
                started        = 1'b1;
                has_switched   = 1'b0;
                raw_grid       = t.grid_seen;
                filtered_grid  = t.grid_seen;
                grid_change_ms = now;
                switch_ms      = now;
                mode_now       = MODE_CHARGE;
            end
            if (t.reading_valid) begin
                if (t.grid_seen != raw_grid) begin
                    raw_grid       = t.grid_seen;
                    grid_change_ms = now;
                end
                elapsed = now - grid_change_ms;
                if (elapsed >= debounce_ms)
                    filtered_grid = raw_grid;
            end
            if (!auto_on) begin
                move_to(forced_mode, now);
            end else if (!t.reading_valid || t.fault_seen) begin
                move_to(MODE_CHARGE, now);
            end else begin
                target = mode_now;
                if (mode_now == MODE_QUIET) begin
                    if (!filtered_grid || t.charge_level <= recharge_pct)
                        target = MODE_CHARGE;
                end else if (filtered_grid && t.charge_level >= quiet_pct) begin
                    target = MODE_QUIET;
                end
                if (target != mode_now) begin
                    elapsed = now - switch_ms;
                    if (target == MODE_CHARGE)
                        move_to(MODE_CHARGE, now);
                    else if (!has_switched || elapsed >= dwell_ms)
                        move_to(MODE_QUIET, now);
                end
            end
            expected_modes.push_back(mode_now);
        endfunction

        function void check_mode(logic actual);
            logic wanted;
            if (expected_modes.size() == 0) begin
                $error("charger_mode: result beat with nothing expected, actual %0d", actual);
                mismatches++;
            end else begin
                wanted = expected_modes.pop_front();
                checked++;
                if (wanted == MODE_QUIET)
                    quiet_seen++;
                if (actual !== wanted) begin
                    $error("charger_mode mismatch: expected %0d, actual %0d", wanted, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [TimeWidth-1:0]     s_time_now;
    logic                     s_reading_valid;
    logic                     s_grid_seen;
    logic                     s_fault_seen;
    logic [LevelWidth-1:0]    s_charge_level;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_charger_mode;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_wdata;

    mode_tracker          tracker;
    int unsigned          idle_pct;
    logic                 hold_off_req;
    int unsigned          quiet_cycles;
    int                   phases;
    logic [TimeWidth-1:0] clock_ms;
    logic                 grid_state;

    charger_mode_hysteresis_controller uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_time_now      (s_time_now),
        .s_reading_valid (s_reading_valid),
        .s_grid_seen     (s_grid_seen),
        .s_fault_seen    (s_fault_seen),
        .s_charge_level  (s_charge_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_charger_mode  (m_charger_mode),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_mode(m_charger_mode);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready      = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            m_ready = aresetn && !(idle_pct != 0 && $urandom_range(99) < idle_pct);
        end
    end

    // called and returns at a falling edge; leaves s_valid high for back-to-back beats
    task automatic send_tick(input item_t t);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_time_now      = t.time_now;
        s_reading_valid = t.reading_valid;
        s_grid_seen     = t.grid_seen;
        s_fault_seen    = t.fault_seen;
        s_charge_level  = t.charge_level;
        do @(posedge aclk); while (!s_ready);
        tracker.note_tick(t);
        @(negedge aclk);
    endtask

    task automatic tick(input logic [TimeWidth-1:0] now, input logic valid, input logic grid,
                        input logic fault, input logic [LevelWidth-1:0] level);
        item_t t;
        t.time_now      = now;
        t.reading_valid = valid;
        t.grid_seen     = grid;
        t.fault_seen    = fault;
        t.charge_level  = level;
        send_tick(t);
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (tracker.expected_modes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        tracker.write_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic program_config(input logic [TimeWidth-1:0] debounce, input logic auto_on,
                                  input logic forced, input logic [LevelWidth-1:0] recharge,
                                  input logic [LevelWidth-1:0] quiet,
                                  input logic [TimeWidth-1:0] dwell);
        settle();
        write_reg(REG_DEBOUNCE_INTERVAL, debounce);
        write_reg(REG_AUTO_ENABLE, {31'd0, auto_on});
        write_reg(REG_OVERRIDE_MODE, {31'd0, forced});
        write_reg(REG_RECHARGE_LEVEL, {25'd0, recharge});
        write_reg(REG_QUIET_LEVEL, {25'd0, quiet});
        write_reg(REG_DWELL_INTERVAL, dwell);
        cfg_we = 1'b0;
        phases++;
    endtask

    function automatic logic [TimeWidth-1:0] pick_interval(input int unsigned span);
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(span);
        endcase
    endfunction

    function automatic logic [LevelWidth-1:0] pick_level();
        if ($urandom_range(9) == 0)
            return LevelWidth'($urandom_range(127));
        return LevelWidth'($urandom_range(100));
    endfunction

    task automatic run_random(input int count, input int unsigned step_max);
        item_t       t;
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 3)
                clock_ms = $urandom;
            else if (pick >= 10)
                clock_ms = clock_ms + $urandom_range(step_max);
            if ($urandom_range(99) < 12)
                grid_state = ~grid_state;
            t.time_now      = clock_ms;
            t.reading_valid = $urandom_range(99) < 88;
            t.grid_seen     = grid_state;
            t.fault_seen    = $urandom_range(99) < 8;
            t.charge_level  = pick_level();
            send_tick(t);
        end
    endtask

    initial begin
        tracker         = new();
        idle_pct        = IDLE_PERCENT;
        hold_off_req    = 1'b0;
        quiet_cycles    = 0;
        phases          = 0;
        clock_ms        = 32'd400000;
        grid_state      = 1'b1;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_time_now      = '0;
        s_reading_valid = 1'b0;
        s_grid_seen     = 1'b0;
        s_fault_seen    = 1'b0;
        s_charge_level  = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: first tick unreliable with grid up, dwell skip, debounce edge, wrap
        tick(32'd1000, 1'b0, 1'b1, 1'b0, 7'd95);
        tick(32'd1001, 1'b1, 1'b1, 1'b0, 7'd100);
        tick(32'd1002, 1'b1, 1'b1, 1'b0, 7'd50);
        tick(32'd2000, 1'b1, 1'b1, 1'b0, 7'd95);
        tick(32'd302002, 1'b1, 1'b1, 1'b0, 7'd95);
        tick(32'd302003, 1'b1, 1'b0, 1'b0, 7'd95);
        tick(32'd307002, 1'b1, 1'b0, 1'b0, 7'd95);
        tick(32'd307003, 1'b1, 1'b0, 1'b0, 7'd95);
        tick(32'd307004, 1'b1, 1'b1, 1'b1, 7'd0);
        tick(32'd307005, 1'b0, 1'b0, 1'b0, 7'd127);
        tick(32'd312004, 1'b1, 1'b1, 1'b0, 7'd127);
        tick(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, 7'd64);
        tick(32'h0004_9400, 1'b1, 1'b1, 1'b0, 7'd90);
        tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 7'd51);
        tick(32'h0000_0000, 1'b1, 1'b1, 1'b0, 7'd50);

        // manual override beats validity and fault; spare indexes must be ignored
        program_config(DEBOUNCE_RESET, 1'b0, MODE_QUIET, RECHARGE_RESET, QUIET_RESET,
                       DWELL_RESET);
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, 32'h5A5A_A5A5);
        cfg_we = 1'b0;
        tick(32'd10, 1'b0, 1'b0, 1'b1, 7'd0);
        tick(32'd11, 1'b1, 1'b1, 1'b1, 7'd100);
        tick(32'd12, 1'b1, 1'b0, 1'b0, 7'd30);
        program_config(DEBOUNCE_RESET, 1'b0, MODE_CHARGE, RECHARGE_RESET, QUIET_RESET,
                       DWELL_RESET);
        tick(32'd13, 1'b1, 1'b1, 1'b0, 7'd100);
        tick(32'd14, 1'b0, 1'b1, 1'b0, 7'd100);

        program_config('0, 1'b1, MODE_CHARGE, 7'd0, 7'd0, '0);
        run_random(60, 20);
        program_config('1, 1'b1, MODE_QUIET, 7'd100, 7'd100, '1);
        run_random(60, 40);
        program_config(32'd3, 1'b1, MODE_CHARGE, 7'd127, 7'd127, 32'd10);
        run_random(60, 20);
        program_config(32'd10, 1'b0, MODE_QUIET, 7'd0, 7'd127, '0);
        run_random(60, 20);

        for (int p = 0; p < 8; p++) begin
            program_config(pick_interval(60), $urandom_range(99) < 85, 1'($urandom_range(1)),
                           pick_level(), pick_level(), pick_interval(200));
            idle_pct = (p == 2) ? 0 : IDLE_PERCENT;
            if (p == 5)
                hold_off_req = 1'b1;
            run_random(160, 40);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Ran %0d ticks through %0d register settings; %0d modes checked, %0d quiet.",
                 tracker.ticks, phases, tracker.checked, tracker.quiet_seen);
        if (tracker.mismatches == 0 && tracker.expected_modes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/cmhc_pkg.sv
sv/cmhc_cfg_regs.sv
sv/cmhc_core.sv
sv/charger_mode_hysteresis_controller.sv
sim/charger_mode_hysteresis_controller_test.sv
